// ===== rtl/quaternion_to_euler_macros.svh =====
// Assertion macros shared by the checker.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define Q2E_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen.
`define Q2E_ASSERT_NEVER(lbl, clk, rst_n, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

// ===== rtl/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;

    // Field formats
    localparam int QUAT_W          = 16;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int PITCH_W         = 15;
    localparam int ANGLE_W         = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Datapath widths
    localparam int PROD_W  = 2 * QUAT_W;      // one 16x16 product
    localparam int SUM_W   = PROD_W + 3;      // 2*(a+b) and 1-2*(a+b), no wrap
    localparam int S30_W   = 32;              // sine of pitch in Q2.30
    localparam int MAG_W   = 30;              // |sine| below one
    localparam int RAD_W   = 61;              // 2^60 - s^2
    localparam int ROOT_W  = 31;              // isqrt result
    localparam int ATIN_W  = SUM_W;           // atan2 operand width
    localparam int CW      = 34;              // CORDIC x/y
    localparam int ZW      = 34;              // angle accumulator, Q4.30
    localparam int ZW1     = ZW + 1;
    localparam int SHAMT_W = 5;
    localparam int LEAD_W  = 6;
    localparam int NORM_BIT = 29;

    // Latency bookkeeping
    localparam int PRE_LAT   = 5;             // products, sums, prep, square, radicand
    localparam int ATAN_PRE  = 3;             // detect, normalize, quadrant
    localparam int ROUND_SH  = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] ANG_PI      = ZW'(64'd3373259426);
    localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(64'd1686629713);
    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << (2 * QUAT_FRAC_BITS);

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Items parked beside the square root
    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
        logic signed [S30_W-1:0] s30;
        logic                    clamp;
        logic                    neg;
    } t_side;

    // Round half up to ANGLE_FRAC_BITS
    function automatic logic signed [ZW:0] round_q30(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] t;
        t = ZW1'(z) + (ZW1'(1) <<< (ROUND_SH - 1));
        return t >>> ROUND_SH;
    endfunction

    localparam logic signed [PITCH_W-1:0] PITCH_MAX = PITCH_W'(round_q30(ANG_HALF_PI));
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(round_q30(ANG_PI));

endpackage
`default_nettype wire

// ===== rtl/q2e_isqrt.sv =====
`default_nettype none
module q2e_isqrt
    import q2e_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output t_side                  o_side
);
    localparam int TW = 2 * ROOT_W + 1;

    logic              r_v    [ROOT_W];
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_side             r_side [ROOT_W];

    // one result bit per stage, MSB first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        localparam int B = ROOT_W - 1 - k;
        logic              c_v;
        logic [RAD_W-1:0]  c_rem;
        logic [ROOT_W-1:0] c_root;
        t_side             c_side;
        logic [TW-1:0]     trial;
        logic              ge;

        if (k == 0) begin : g_in
            assign c_v    = i_valid;
            assign c_rem  = i_rad;
            assign c_root = '0;
            assign c_side = i_side;
        end else begin : g_mid
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_side = r_side[k-1];
        end

        assign trial = (TW'(c_root) << (B + 1)) + (TW'(1) << (2 * B));
        assign ge    = TW'(c_rem) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= c_v;
            end
            r_rem[k]  <= ge ? RAD_W'(TW'(c_rem) - trial) : c_rem;
            r_root[k] <= ge ? (c_root | (ROOT_W'(1) << B)) : c_root;
            r_side[k] <= c_side;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/q2e_atan2.sv =====
`default_nettype none
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic signed [ATIN_W-1:0] i_y,
    input  wire logic signed [ATIN_W-1:0] i_x,
    output logic                         o_valid,
    output logic signed [ZW-1:0]         o_angle
);
    // --- stage A: leading-one detect on max(|x|,|y|)
    logic [ATIN_W-1:0] mx, my, mm;
    logic [LEAD_W-1:0] lead;

    always_comb begin
        mx   = i_x[ATIN_W-1] ? ATIN_W'(-i_x) : ATIN_W'(i_x);
        my   = i_y[ATIN_W-1] ? ATIN_W'(-i_y) : ATIN_W'(i_y);
        mm   = (mx > my) ? mx : my;
        lead = '0;
        for (int j = 0; j < ATIN_W; j++) begin
            if (mm[j]) lead = LEAD_W'(j);
        end
    end

    logic                     rA_v, rA_zero, rA_shr;
    logic [SHAMT_W-1:0]       rA_amt;
    logic signed [ATIN_W-1:0] rA_x, rA_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
        end else begin
            rA_v <= i_valid;
        end
        rA_x    <= i_x;
        rA_y    <= i_y;
        rA_zero <= (mm == '0);
        rA_shr  <= lead > LEAD_W'(NORM_BIT);
        rA_amt  <= (lead > LEAD_W'(NORM_BIT)) ? SHAMT_W'(lead - LEAD_W'(NORM_BIT))
                                              : SHAMT_W'(LEAD_W'(NORM_BIT) - lead);
    end

    // --- stage B: shift so the larger magnitude has its top bit at NORM_BIT
    logic                 rB_v, rB_zero;
    logic signed [CW-1:0] rB_x, rB_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_v <= 1'b0;
        end else begin
            rB_v <= rA_v;
        end
        rB_zero <= rA_zero;
        rB_x    <= rA_shr ? CW'(rA_x >>> rA_amt) : CW'(rA_x <<< rA_amt);
        rB_y    <= rA_shr ? CW'(rA_y >>> rA_amt) : CW'(rA_y <<< rA_amt);
    end

    // --- stage C: fold left half plane by a quarter turn
    logic                 rC_v, rC_zero;
    logic signed [CW-1:0] rC_x, rC_y;
    logic signed [ZW-1:0] rC_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_v <= 1'b0;
        end else begin
            rC_v <= rB_v;
        end
        rC_zero <= rB_zero;
        if (rB_x < 0 && rB_y >= 0) begin
            rC_x <= rB_y;
            rC_y <= -rB_x;
            rC_z <= ANG_HALF_PI;
        end else if (rB_x < 0) begin
            rC_x <= -rB_y;
            rC_y <= rB_x;
            rC_z <= -ANG_HALF_PI;
        end else begin
            rC_x <= rB_x;
            rC_y <= rB_y;
            rC_z <= '0;
        end
    end

    // --- CORDIC vectoring, one micro-rotation per stage
    logic                 r_cv    [STAGES];
    logic                 r_czero [STAGES];
    logic signed [CW-1:0] r_cx    [STAGES];
    logic signed [CW-1:0] r_cy    [STAGES];
    logic signed [ZW-1:0] r_cz    [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_cordic
        logic                 c_v, c_zero, up;
        logic signed [CW-1:0] c_x, c_y;
        logic signed [ZW-1:0] c_z, ang;

        if (k == 0) begin : g_in
            assign c_v    = rC_v;
            assign c_zero = rC_zero;
            assign c_x    = rC_x;
            assign c_y    = rC_y;
            assign c_z    = rC_z;
        end else begin : g_mid
            assign c_v    = r_cv[k-1];
            assign c_zero = r_czero[k-1];
            assign c_x    = r_cx[k-1];
            assign c_y    = r_cy[k-1];
            assign c_z    = r_cz[k-1];
        end

        assign ang = ZW'(ATAN_TAB[k]);
        assign up  = !c_y[CW-1] && (c_y != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else begin
                r_cv[k] <= c_v;
            end
            r_czero[k] <= c_zero;
            r_cx[k] <= up ? c_x + (c_y >>> k) : c_x - (c_y >>> k);
            r_cy[k] <= up ? c_y - (c_x >>> k) : c_y + (c_x >>> k);
            r_cz[k] <= up ? c_z + ang : c_z - ang;
        end
    end

    // --- saturate to +-pi, zero vector gives zero
    logic signed [ZW-1:0] zl;
    assign zl = r_cz[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cv[STAGES-1];
        end
        if (r_czero[STAGES-1]) begin
            o_angle <= '0;
        end else if (zl > ANG_PI) begin
            o_angle <= ANG_PI;
        end else if (zl < -ANG_PI) begin
            o_angle <= -ANG_PI;
        end else begin
            o_angle <= zl;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler.sv =====
`default_nettype none
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  --------------------------
// input     i_quat_w, i_quat_x, i_quat_y, i_quat_z        i_start && !o_busy
// result    o_pitch_angle, o_yaw_angle, o_roll_angle,     o_valid, one cycle,
//           o_pitch_clamped                               cannot be held off
//
// A transfer can be taken every cycle; the pipeline never stalls, so o_busy stays low.
// The latency is set by the product, sum and radicand stages, the 31-stage square root and the CORDIC chain.
// Reset is synchronous, active low, and clears only the valid bits of every stage.
// Each result shows for exactly one cycle, in input order.
module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic signed [QUAT_W-1:0]  i_quat_w,
    input  wire logic signed [QUAT_W-1:0]  i_quat_x,
    input  wire logic signed [QUAT_W-1:0]  i_quat_y,
    input  wire logic signed [QUAT_W-1:0]  i_quat_z,
    output logic                           o_valid,
    output logic signed [PITCH_W-1:0]      o_pitch_angle,
    output logic signed [ANGLE_W-1:0]      o_yaw_angle,
    output logic signed [ANGLE_W-1:0]      o_roll_angle,
    output logic                           o_pitch_clamped
);
    localparam int ATAN_LAT = ATAN_PRE + CORDIC_STAGES + 1;

    // fully pipelined, always ready
    assign o_busy = 1'b0;

    // --- stage 1: the nine products
    logic                     r1_v;
    logic signed [PROD_W-1:0] r1_wx, r1_yz, r1_xx, r1_yy, r1_wz, r1_xy, r1_zz, r1_wy, r1_zx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start && !o_busy;
        end
        r1_wx <= i_quat_w * i_quat_x;
        r1_yz <= i_quat_y * i_quat_z;
        r1_xx <= i_quat_x * i_quat_x;
        r1_yy <= i_quat_y * i_quat_y;
        r1_wz <= i_quat_w * i_quat_z;
        r1_xy <= i_quat_x * i_quat_y;
        r1_zz <= i_quat_z * i_quat_z;
        r1_wy <= i_quat_w * i_quat_y;
        r1_zx <= i_quat_z * i_quat_x;
    end

    // --- stage 2: sine/cosine terms at full width, Q.28
    logic                    r2_v;
    logic signed [SUM_W-1:0] r2_sinr, r2_cosr, r2_siny, r2_cosy, r2_sinp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_sinr <= (SUM_W'(r1_wx) + SUM_W'(r1_yz)) <<< 1;
        r2_cosr <= ONE_Q - ((SUM_W'(r1_xx) + SUM_W'(r1_yy)) <<< 1);
        r2_siny <= (SUM_W'(r1_wz) + SUM_W'(r1_xy)) <<< 1;
        r2_cosy <= ONE_Q - ((SUM_W'(r1_yy) + SUM_W'(r1_zz)) <<< 1);
        r2_sinp <= (SUM_W'(r1_wy) - SUM_W'(r1_zx)) <<< 1;
    end

    // --- stage 3: gimbal-lock test, pitch sine to Q2.30
    logic                    r3_v;
    logic [MAG_W-1:0]        r3_mag;
    t_side                   r3_side;
    logic signed [S30_W-1:0] s30;

    // only meaningful when not clamped, where |sinp| < 2^28
    assign s30 = S30_W'(r2_sinp) <<< (30 - 2 * QUAT_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_mag        <= s30[S30_W-1] ? MAG_W'(-s30) : MAG_W'(s30);
        r3_side.sinr  <= r2_sinr;
        r3_side.cosr  <= r2_cosr;
        r3_side.siny  <= r2_siny;
        r3_side.cosy  <= r2_cosy;
        r3_side.s30   <= s30;
        r3_side.clamp <= (r2_sinp >= ONE_Q) || (r2_sinp <= -ONE_Q);
        r3_side.neg   <= r2_sinp[SUM_W-1];
    end

    // --- stage 4: s^2
    logic                   r4_v;
    logic [2*MAG_W-1:0]     r4_sq;
    t_side                  r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_sq   <= r3_mag * r3_mag;
        r4_side <= r3_side;
    end

    // --- stage 5: radicand 1 - s^2 in Q.60
    logic             r5_v;
    logic [RAD_W-1:0] r5_rad;
    t_side            r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_rad  <= (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(r4_sq);
        r5_side <= r4_side;
    end

    // --- cosine of pitch by digit-serial square root
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    q2e_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // --- three atan2 pipelines in lockstep
    logic                 pa_v;
    logic signed [ZW-1:0] pa_z, ya_z, ra_z;

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_y     (ATIN_W'(sq_side.s30)),
        .i_x     (ATIN_W'(sq_root)),
        .o_valid (pa_v),
        .o_angle (pa_z)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_y     (sq_side.siny),
        .i_x     (sq_side.cosy),
        .o_valid (),
        .o_angle (ya_z)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_y     (sq_side.sinr),
        .i_x     (sq_side.cosr),
        .o_valid (),
        .o_angle (ra_z)
    );

    // clamp flag and sign ride alongside the atan2 pipelines
    logic r_dl_clamp [ATAN_LAT];
    logic r_dl_neg   [ATAN_LAT];

    always_ff @(posedge i_clk) begin
        r_dl_clamp[0] <= sq_side.clamp;
        r_dl_neg[0]   <= sq_side.neg;
        for (int j = 1; j < ATAN_LAT; j++) begin
            r_dl_clamp[j] <= r_dl_clamp[j-1];
            r_dl_neg[j]   <= r_dl_neg[j-1];
        end
    end

    // --- output register: pitch clamp, rounding to Q3.13 (pitch to Q2.13)
    logic signed [ZW-1:0] pitch_z;

    always_comb begin
        if (r_dl_clamp[ATAN_LAT-1]) begin
            pitch_z = r_dl_neg[ATAN_LAT-1] ? -ANG_HALF_PI : ANG_HALF_PI;
        end else if (pa_z > ANG_HALF_PI) begin
            pitch_z = ANG_HALF_PI;
        end else if (pa_z < -ANG_HALF_PI) begin
            pitch_z = -ANG_HALF_PI;
        end else begin
            pitch_z = pa_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= pa_v;
        end
        o_pitch_angle   <= PITCH_W'(round_q30(pitch_z));
        o_yaw_angle     <= ANGLE_W'(round_q30(ya_z));
        o_roll_angle    <= ANGLE_W'(round_q30(ra_z));
        o_pitch_clamped <= r_dl_clamp[ATAN_LAT-1];
    end

endmodule
`default_nettype wire

// ===== rtl/q2e_checker.sv =====
`default_nettype none
`include "quaternion_to_euler_macros.svh"
module q2e_checker
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_start,
    input wire logic                     o_busy,
    input wire logic signed [QUAT_W-1:0] i_quat_w,
    input wire logic signed [QUAT_W-1:0] i_quat_x,
    input wire logic signed [QUAT_W-1:0] i_quat_y,
    input wire logic signed [QUAT_W-1:0] i_quat_z,
    input wire logic                     o_valid,
    input wire logic signed [PITCH_W-1:0] o_pitch_angle,
    input wire logic signed [ANGLE_W-1:0] o_yaw_angle,
    input wire logic signed [ANGLE_W-1:0] o_roll_angle,
    input wire logic                     o_pitch_clamped
);
    localparam int LAT = PRE_LAT + ROOT_W + ATAN_PRE + CORDIC_STAGES + 2;

    logic in_ok;
    assign in_ok = (i_quat_w == i_quat_w) && (i_quat_x == i_quat_x)
                && (i_quat_y == i_quat_y) && (i_quat_z == i_quat_z);

    // clamped pitch sits exactly on +-pi/2
    logic clamp_ok;
    assign clamp_ok = (o_pitch_angle == PITCH_MAX) || (o_pitch_angle == -PITCH_MAX);

    // every angle inside its saturation window
    logic range_ok;
    assign range_ok = (o_yaw_angle <= ANGLE_MAX) && (o_yaw_angle >= -ANGLE_MAX)
                   && (o_roll_angle <= ANGLE_MAX) && (o_roll_angle >= -ANGLE_MAX)
                   && (o_pitch_angle <= PITCH_MAX) && (o_pitch_angle >= -PITCH_MAX);

    `Q2E_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, o_busy && in_ok, "busy raised")
    `Q2E_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, o_valid, $past(i_start, LAT), "result without transfer")
    `Q2E_ASSERT_IMPLY(a_clamp_val, i_clk, i_rst_n, o_valid && o_pitch_clamped, clamp_ok, "clamped pitch off")
    `Q2E_ASSERT_IMPLY(a_range, i_clk, i_rst_n, o_valid, range_ok, "angle out of range")

endmodule

bind quaternion_to_euler q2e_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_q2e_checker (.*);
`default_nettype wire
